>>> hw/rtl/frmse_pkg.sv
// Shared widths and control types for the factor-model RMSE block.
`timescale 1ns / 1ps
`default_nettype none
package frmse_pkg;

    // Multiplier operand and product widths (signed)
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    // Accumulator and result widths
    localparam int ACC_W  = 48;
    localparam int SUM_W  = 64;
    localparam int CNT_W  = 32;
    localparam int RMSE_W = 16;

    // Rating is Q8.8, the prediction is Q.28
    localparam int RATING_SHIFT = 20;

    // Requests from the sequencer to the divide/root unit
    typedef struct packed {
        logic start;
        logic ack;
    } t_ds_ctrl;

    // Status back from the divide/root unit
    typedef struct packed {
        logic idle;
        logic done;
    } t_ds_stat;

endpackage
`default_nettype wire

>>> hw/rtl/frmse_divsqrt.sv
// Iterative divide and integer square root sharing one compare-subtract unit.
`timescale 1ns / 1ps
`default_nettype none
module frmse_divsqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire frmse_pkg::t_ds_ctrl           i_ctrl,
    input  wire logic [frmse_pkg::SUM_W-1:0]   i_dividend,
    input  wire logic [frmse_pkg::CNT_W-1:0]   i_divisor,
    output frmse_pkg::t_ds_stat                o_stat,
    output logic      [frmse_pkg::RMSE_W-1:0]  o_root
);
    import frmse_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam int REM_W  = CNT_W + 1;
    localparam int SUB_W  = REM_W + 2;

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_DIV  = 4'b0010,
        P_SQRT = 4'b0100,
        P_DONE = 4'b1000
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [SUM_W-1:0]     r_q, n_q;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_root, n_root;
    logic [CNT_W-1:0]     r_divisor;
    logic [RMSE_W-1:0]    r_result, n_result;

    logic [SUB_W-1:0]     sub_a, sub_b;
    logic [SUB_W:0]       sub_diff;
    logic                 sub_borrow;

    // Shared compare-subtract: one quotient bit or one root bit per cycle
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        case (r_phase)
            P_DIV: begin
                sub_a = {2'b00, r_rem[CNT_W-1:0], r_q[SUM_W-1]};
                sub_b = {3'b000, r_divisor};
            end
            P_SQRT: begin
                sub_a = {r_rem, r_q[SUM_W-1 -: 2]};
                sub_b = {1'b0, r_root, 2'b01};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
        sub_borrow = sub_diff[SUB_W];
    end

    // Sequencer for the two iterations
    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_q      = r_q;
        n_rem    = r_rem;
        n_root   = r_root;
        n_result = r_result;
        case (r_phase)
            P_IDLE: begin
                if (i_ctrl.start) begin
                    n_phase = P_DIV;
                    n_step  = STEP_W'(SUM_W - 1);
                    n_q     = i_dividend;
                    n_rem   = '0;
                end
            end
            P_DIV: begin
                n_rem = sub_borrow ? sub_a[REM_W-1:0] : sub_diff[REM_W-1:0];
                n_q   = {r_q[SUM_W-2:0], ~sub_borrow};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_phase = P_SQRT;
                    n_step  = STEP_W'(SUM_W / 2 - 1);
                    n_rem   = '0;
                    n_root  = '0;
                end
            end
            P_SQRT: begin
                n_rem  = sub_borrow ? sub_a[REM_W-1:0] : sub_diff[REM_W-1:0];
                n_q    = {r_q[SUM_W-3:0], 2'b00};
                n_root = {r_root[CNT_W-2:0], ~sub_borrow};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_phase = P_DONE;
                    // clip roots that do not fit Q8.8
                    if (|n_root[CNT_W-1:RMSE_W]) begin
                        n_result = '1;
                    end else begin
                        n_result = n_root[RMSE_W-1:0];
                    end
                end
            end
            P_DONE: begin
                if (i_ctrl.ack) begin
                    n_phase = P_IDLE;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_step  <= '0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_result <= n_result;
        if (r_phase == P_IDLE && i_ctrl.start) begin
            r_divisor <= i_divisor;
        end
    end

    assign o_stat.idle = (r_phase == P_IDLE);
    assign o_stat.done = (r_phase == P_DONE);
    assign o_root      = r_result;

    // A start always launches the divide
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_IDLE && i_ctrl.start) |=> (r_phase == P_DIV))
        else $error("divide did not start");

    // Last divide step hands over to the root
    a_div_to_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_DIV && r_step == '0) |=> (r_phase == P_SQRT))
        else $error("root did not follow divide");

    // Root remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_SQRT) |-> (r_rem <= {r_root, 1'b0}))
        else $error("root remainder out of range");

endmodule
`default_nettype wire

>>> hw/rtl/factor_model_rmse.sv
// Top level: dot-product error accumulation and RMSE sequencer.
//
// Input channel (i_in_valid / o_in_ready) takes one factor element pair per
// item; last_element closes a rating, and rating / last_rating are read
// with it. Output channel (o_out_valid / i_out_ready) carries one result
// per set: the RMSE in Q8.8, the rating count and two flags.
// One shared multiplier serves the element products and the error square.
// An ordinary element pair passes through product and accumulate; a pair
// that closes a rating goes on (product, accumulate, error, round, square, sum).
// A pair that closes the set then launches the divide/root unit: restoring
// division of the 64-bit sum by the count, then the square root of the
// quotient, one compare-subtract per quotient or root bit. The input side
// is not ready while any item is in work.
// The result sits in an output register that a stalled receiver holds; a
// following set's result waits for it to drain, and the input stays blocked.
// Reset clears the running sums and counts and r_sat, and drops o_out_valid.
`timescale 1ns / 1ps
`default_nettype none
module factor_model_rmse #(
    parameter int MAX_RANK = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [15:0]                   i_factor_a,
    input  wire logic signed [15:0]                   i_factor_b,
    input  wire logic                                 i_last_element,
    input  wire logic        [15:0]                   i_rating,
    input  wire logic                                 i_last_rating,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic             [frmse_pkg::RMSE_W-1:0]  o_rmse_value,
    output logic             [frmse_pkg::CNT_W-1:0]   o_rating_count,
    output logic                                      o_empty_set,
    output logic                                      o_sum_saturated
);
    import frmse_pkg::*;

    localparam int EW = $clog2(MAX_RANK + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_ACC  = 8'b0000_0100,
        S_ERR  = 8'b0000_1000,
        S_RND  = 8'b0001_0000,
        S_SQ   = 8'b0010_0000,
        S_SUM  = 8'b0100_0000,
        S_DIV  = 8'b1000_0000
    } t_state;

    t_state                    r_state, n_state;

    // latched item
    logic signed [15:0]        r_a, r_b;
    logic                      r_last_el, r_last_rt;
    logic [15:0]               r_rating;

    // accumulators
    logic signed [ACC_W-1:0]   r_pred;
    logic [EW-1:0]             r_elems;
    logic [SUM_W-1:0]          r_sum;
    logic [CNT_W-1:0]          r_ratings;
    logic                      r_sat;

    // datapath pipeline
    logic signed [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]          r_err;
    logic [MUL_W-2:0]          r_e8;

    // output register
    logic                      r_out_valid;
    logic [RMSE_W-1:0]         r_rmse;
    logic [CNT_W-1:0]          r_count;
    logic                      r_empty;
    logic                      r_sat_out;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [ACC_W:0]     err_diff;
    logic [ACC_W-1:0]          err_rnd;
    logic [SUM_W:0]            sum_next;
    logic                      in_accept;
    logic                      out_load;

    t_ds_ctrl                  ds_ctrl;
    t_ds_stat                  ds_stat;
    logic [RMSE_W-1:0]         ds_root;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_load  = (r_state == S_DIV) && ds_stat.done &&
                       (!r_out_valid || i_out_ready);

    // Shared multiplier operand select
    always_comb begin
        if (r_state == S_SQ) begin
            mul_a = {1'b0, r_e8};
            mul_b = {1'b0, r_e8};
        end else begin
            mul_a = {{(MUL_W-16){r_a[15]}}, r_a};
            mul_b = {{(MUL_W-16){r_b[15]}}, r_b};
        end
    end

    // Error in Q.28 and its magnitude rounded to Q.8
    assign err_diff = {r_pred[ACC_W-1], r_pred} -
                      $signed({{(ACC_W + 1 - 16 - RATING_SHIFT){1'b0}}, r_rating,
                               {RATING_SHIFT{1'b0}}});
    assign err_rnd  = r_err + (ACC_W'(1) << (RATING_SHIFT - 1));

    // Saturating squared-error sum
    assign sum_next = {1'b0, r_sum} + {{(SUM_W + 1 - PROD_W){1'b0}}, r_prod};

    // Sequencer
    always_comb begin
        n_state       = r_state;
        ds_ctrl.start = 1'b0;
        ds_ctrl.ack   = out_load;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = r_last_el ? S_ERR : S_IDLE;
            S_ERR: n_state = S_RND;
            S_RND: n_state = S_SQ;
            S_SQ:  n_state = S_SUM;
            S_SUM: begin
                if (r_last_rt) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                // launch once the final sum and count are registered
                ds_ctrl.start = ds_stat.idle;
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pred      <= '0;
            r_elems     <= '0;
            r_sum       <= '0;
            r_ratings   <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // element accumulate, extra elements past the rank are dropped
            if (r_state == S_ACC) begin
                if (r_elems < EW'(MAX_RANK)) begin
                    r_pred <= r_pred + r_prod;
                end
                if (r_last_el) begin
                    r_elems <= '0;
                end else if (r_elems < EW'(MAX_RANK)) begin
                    r_elems <= r_elems + 1'b1;
                end
            end
            if (r_state == S_ERR) begin
                r_pred <= '0;
            end
            // rating close: sum and count
            if (r_state == S_SUM) begin
                if (sum_next[SUM_W]) begin
                    r_sum <= '1;
                    r_sat <= 1'b1;
                end else begin
                    r_sum <= sum_next[SUM_W-1:0];
                end
                if (r_ratings != '1) begin
                    r_ratings <= r_ratings + 1'b1;
                end
            end
            // set close: result to output register, state back to reset
            if (out_load) begin
                r_sum       <= '0;
                r_ratings   <= '0;
                r_sat       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a       <= i_factor_a;
            r_b       <= i_factor_b;
            r_last_el <= i_last_element;
            r_rating  <= i_rating;
            r_last_rt <= i_last_rating;
        end
        if (r_state == S_MUL || r_state == S_SQ) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_ERR) begin
            r_err <= err_diff[ACC_W] ? ACC_W'(-err_diff) : err_diff[ACC_W-1:0];
        end
        if (r_state == S_RND) begin
            r_e8 <= err_rnd[RATING_SHIFT + MUL_W - 2 : RATING_SHIFT];
        end
        if (out_load) begin
            r_empty   <= (r_ratings == '0);
            r_rmse    <= (r_ratings == '0) ? '0 : ds_root;
            r_count   <= r_ratings;
            r_sat_out <= r_sat;
        end
    end

    frmse_divsqrt u_divsqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ds_ctrl),
        .i_dividend (r_sum),
        .i_divisor  (r_ratings),
        .o_stat     (ds_stat),
        .o_root     (ds_root)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_rmse_value    = r_rmse;
    assign o_rating_count  = r_count;
    assign o_empty_set     = r_empty;
    assign o_sum_saturated = r_sat_out;

    // Element count stays within the rank
    a_elems_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elems <= EW'(MAX_RANK))
        else $error("element count above rank");

    // Divide/root unit is only started when free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_ctrl.start |-> ds_stat.idle)
        else $error("divide/root unit started while busy");

    // A set always has at least one counted rating when it closes
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_ratings != '0))
        else $error("set closed with no ratings");

    // An accepted item blocks the input for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input ready while item in work");

endmodule
`default_nettype wire

>>> tb/tb_factor_model_rmse.sv
// Self-checking testbench for factor_model_rmse: random factor sets against a tracked RMSE.
`timescale 1ns / 1ps
module tb_factor_model_rmse;
    import frmse_pkg::*;

    localparam int          RANK_LIMIT    = 64;
    localparam int unsigned ITEM_TARGET   = 800;
    localparam int unsigned RESULT_TARGET = 20;
    localparam int          DRAIN_CYCLES  = 150;
    localparam int unsigned TIMEOUT_NS    = 1_000_000;

    typedef struct packed {
        logic [RMSE_W-1:0] rmse;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              saturated;
    } t_rmse_result;

    // How element values are drawn for one rating
    typedef enum {
        VAL_FULL,
        VAL_SMALL,
        VAL_EXTREME,
        VAL_MAX_POS,
        VAL_MAX_NEG
    } t_factor_mode;

    // Tracks the dot product, error sum and count; queues expected RMSE results
    class t_rmse_tracker;
        logic signed [ACC_W-1:0] dot_acc;
        logic [SUM_W-1:0]        sq_err_sum;
        logic [CNT_W-1:0]        ratings;
        logic                    sat;
        int unsigned             pairs;
        t_rmse_result            expected_rmse[$];
        int unsigned             mismatches;
        int unsigned             sets_closed;

        function new();
            clear();
            mismatches  = 0;
            sets_closed = 0;
        endfunction

        function void clear();
            dot_acc    = '0;
            sq_err_sum = '0;
            ratings    = '0;
            sat        = 1'b0;
            pairs      = 0;
        endfunction

        // Bitwise floor square root, top bit first
        function logic [SUM_W-1:0] floor_root(input logic [SUM_W-1:0] n);
            logic [SUM_W-1:0] root;
            logic [SUM_W-1:0] trial;
            root = '0;
            for (int i = 31; i >= 0; i--) begin
                trial = root | (64'd1 << i);
                if (trial * trial <= n) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        // One accepted element pair
        function void add_element_pair(input logic signed [15:0] a,
                                       input logic signed [15:0] b,
                                       input logic last_el,
                                       input logic [15:0] rating,
                                       input logic last_rt);
            longint           prod;
            longint           err28;
            longint           mag;
            longint           e8;
            logic [SUM_W-1:0] sq;
            logic [SUM_W-1:0] mean;
            logic [SUM_W-1:0] root;
            t_rmse_result     res;

            // pairs past the rank limit are dropped
            if (pairs < RANK_LIMIT) begin
                prod    = longint'(a) * longint'(b);
                dot_acc = dot_acc + prod[ACC_W-1:0];
                pairs++;
            end
            if (!last_el) begin
                return;
            end

            // error in Q.28, rounded half away from zero to Q.8
            err28 = longint'(dot_acc) - (longint'(rating) <<< RATING_SHIFT);
            mag   = (err28 < 0) ? -err28 : err28;
            e8    = (mag + (longint'(1) <<< (RATING_SHIFT - 1))) >>> RATING_SHIFT;
            sq    = e8 * e8;
            if (sq_err_sum > ~sq) begin
                sq_err_sum = '1;
                sat        = 1'b1;
            end else begin
                sq_err_sum = sq_err_sum + sq;
            end
            if (ratings != '1) begin
                ratings = ratings + 32'd1;
            end
            dot_acc = '0;
            pairs   = 0;
            if (!last_rt) begin
                return;
            end

            // close the set
            res.count     = ratings;
            res.empty     = (ratings == '0);
            res.saturated = sat;
            if (ratings == '0) begin
                res.rmse = '0;
            end else begin
                mean = sq_err_sum / {32'd0, ratings};
                root = floor_root(mean);
                res.rmse = (root > 64'h0000_0000_0000_FFFF) ? '1 : root[RMSE_W-1:0];
            end
            expected_rmse.push_back(res);
            sets_closed++;
            clear();
        endfunction

        task report(input string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // One accepted result against the oldest expectation
        task compare_result(input t_rmse_result got);
            t_rmse_result want;
            if (expected_rmse.size() == 0) begin
                report($sformatf("unexpected result rmse=%h count=%0d", got.rmse, got.count));
                return;
            end
            want = expected_rmse.pop_front();
            if (got.rmse !== want.rmse) begin
                report($sformatf("rmse_value got %h want %h", got.rmse, want.rmse));
            end
            if (got.count !== want.count) begin
                report($sformatf("rating_count got %0d want %0d", got.count, want.count));
            end
            if (got.empty !== want.empty) begin
                report($sformatf("empty_set got %b want %b", got.empty, want.empty));
            end
            if (got.saturated !== want.saturated) begin
                report($sformatf("sum_saturated got %b want %b", got.saturated,
                                 want.saturated));
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic signed [15:0]      i_factor_a;
    logic signed [15:0]      i_factor_b;
    logic                    i_last_element;
    logic [15:0]             i_rating;
    logic                    i_last_rating;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [RMSE_W-1:0]       o_rmse_value;
    logic [CNT_W-1:0]        o_rating_count;
    logic                    o_empty_set;
    logic                    o_sum_saturated;

    t_rmse_tracker tracker;
    int unsigned items_sent = 0;
    bit          in_burst   = 1'b0;

    factor_model_rmse #(
        .MAX_RANK(RANK_LIMIT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_factor_a     (i_factor_a),
        .i_factor_b     (i_factor_b),
        .i_last_element (i_last_element),
        .i_rating       (i_rating),
        .i_last_rating  (i_last_rating),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_rmse_value   (o_rmse_value),
        .o_rating_count (o_rating_count),
        .o_empty_set    (o_empty_set),
        .o_sum_saturated(o_sum_saturated)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Element value for a given draw mode
    function logic signed [15:0] pick_factor(input t_factor_mode mode);
        logic [31:0] r32;
        r32 = $urandom;
        case (mode)
            VAL_SMALL: begin
                return r32[15:0] % 16'd2048 - 16'd1024;
            end
            VAL_EXTREME: begin
                case (r32[18:16])
                    3'd0:    return 16'sh8000;
                    3'd1:    return 16'sh7FFF;
                    3'd2:    return 16'sh0000;
                    3'd3:    return 16'shFFFF;
                    3'd4:    return 16'sh0001;
                    default: return 16'sh4000;
                endcase
            end
            default: begin
                return r32[15:0];
            end
        endcase
    endfunction

    // Present one element pair and wait for it to be taken
    task drive_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                    input logic last_el, input logic [15:0] rating, input logic last_rt);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0) begin
            in_burst = !in_burst;
        end
        gap = in_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_factor_a     <= a;
        i_factor_b     <= b;
        i_last_element <= last_el;
        i_rating       <= rating;
        i_last_rating  <= last_rt;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.add_element_pair(a, b, last_el, rating, last_rt);
        items_sent++;
    endtask

    // One rating of len pairs; inner pairs carry junk rating and last_rating
    task send_rating(input int unsigned len, input t_factor_mode mode,
                     input logic [15:0] rating, input logic closes_set);
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic [31:0]        noise;
        for (int unsigned k = 0; k < len; k++) begin
            noise = $urandom;
            case (mode)
                VAL_MAX_POS: begin
                    a = 16'sh8000;
                    b = 16'sh8000;
                end
                VAL_MAX_NEG: begin
                    a = 16'sh8000;
                    b = 16'sh7FFF;
                end
                default: begin
                    a = pick_factor(mode);
                    b = pick_factor(mode);
                end
            endcase
            if (k == len - 1) begin
                drive_pair(a, b, 1'b1, rating, closes_set);
            end else begin
                drive_pair(a, b, 1'b0, noise[15:0], noise[16]);
            end
        end
    endtask

    // A random set: mostly short ratings, some long, a few past the rank limit
    task run_random_set();
        int unsigned  nrat;
        int unsigned  len;
        int unsigned  sel;
        t_factor_mode mode;
        logic [31:0]  r32;
        logic [15:0]  rating;
        nrat = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        for (int unsigned r = 0; r < nrat; r++) begin
            sel = $urandom_range(0, 19);
            if (sel < 17) begin
                len = $urandom_range(1, 6);
            end else if (sel < 19) begin
                len = $urandom_range(7, RANK_LIMIT);
            end else begin
                len = $urandom_range(RANK_LIMIT + 1, RANK_LIMIT + 8);
            end
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                mode = VAL_FULL;
            end else if (sel < 65) begin
                mode = VAL_SMALL;
            end else if (sel < 85) begin
                mode = VAL_EXTREME;
            end else if (sel < 93) begin
                mode = VAL_MAX_POS;
            end else begin
                mode = VAL_MAX_NEG;
            end
            r32 = $urandom;
            // small products need small ratings to land near rounding points
            if (mode == VAL_SMALL && r32[20]) begin
                rating = {12'd0, r32[3:0]};
            end else begin
                rating = r32[15:0];
            end
            send_rating(len, mode, rating, r == nrat - 1);
        end
    endtask

    // Stimulus and end of run
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_factor_a     = '0;
        i_factor_b     = '0;
        i_last_element = 1'b0;
        i_rating       = '0;
        i_last_rating  = 1'b0;
        tracker        = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest set: one zero pair
        drive_pair(16'sd0, 16'sd0, 1'b1, 16'h0000, 1'b1);
        // full-scale products; last_rating on an inner pair must be ignored
        drive_pair(16'sh7FFF, 16'sh7FFF, 1'b0, 16'h1234, 1'b1);
        drive_pair(16'sh8000, 16'sh8000, 1'b1, 16'hFFFF, 1'b0);
        drive_pair(16'sh8000, 16'sh7FFF, 1'b1, 16'h8000, 1'b1);
        // error of exactly half an LSB both ways, just under half, exact match
        drive_pair(16'sd1024, 16'sd512, 1'b1, 16'h0000, 1'b0);
        drive_pair(-16'sd1024, 16'sd512, 1'b1, 16'h0000, 1'b0);
        drive_pair(16'sd1023, 16'sd512, 1'b1, 16'h0000, 1'b0);
        drive_pair(16'sh4000, 16'sh4000, 1'b1, 16'h0100, 1'b1);
        // root above 16 bits clips to all ones
        drive_pair(-16'sd1024, 16'sd1024, 1'b1, 16'hFFFF, 1'b1);
        // Sum saturation needs about 2^30 ratings, count saturation 2^32, and an
        // empty set cannot be formed, so those stay out of reach here.

        // more pairs than the rank limit in one rating
        send_rating(RANK_LIMIT + 6, VAL_FULL, 16'h5A5A, 1'b1);
        while (items_sent < ITEM_TARGET || tracker.sets_closed < RESULT_TARGET) begin
            run_random_set();
        end
        i_in_valid <= 1'b0;

        while (tracker.expected_rmse.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_rmse.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result side: random stalls with bursts of constant ready
    initial begin
        t_rmse_result got;
        int unsigned  stall;
        bit           out_burst;
        out_burst   = 1'b0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0) begin
                out_burst = !out_burst;
            end
            stall = out_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.rmse      = o_rmse_value;
            got.count     = o_rating_count;
            got.empty     = o_empty_set;
            got.saturated = o_sum_saturated;
            tracker.compare_result(got);
        end
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/frmse_pkg.sv
hw/rtl/frmse_divsqrt.sv
hw/rtl/factor_model_rmse.sv
tb/tb_factor_model_rmse.sv
